@@ rtl/bfdh_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfdh_pkg
// Shared constants, codes and helpers of the double-hash Bloom filter.
// ----------------------------------------------------------------------------
package bfdh_pkg;

	localparam int MAX_BITS_DEFAULT = 8192;

	localparam logic [13:0] FILTER_BITS_RST = 14'd64;
	localparam logic [4:0]  PROBE_COUNT_RST = 5'd6;
	localparam int          MIN_FILTER_BITS = 64;
	localparam logic [4:0]  MIN_PROBES      = 5'd1;
	localparam logic [4:0]  MAX_PROBES      = 5'd30;
	localparam int          STEP_ROT        = 17;

	// remainder unit: bits retired per cycle, steps per 32-bit dividend
	localparam int DIV_BITS  = 4;
	localparam int DIV_STEPS = 32 / DIV_BITS;
	localparam int DIV_CW    = $clog2(DIV_STEPS);

	localparam int LANES     = 3;
	localparam int LANE_HASH = 0;
	localparam int LANE_STEP = 1;
	localparam int LANE_WRAP = 2;

	localparam int QUEUE_DEPTH = 2;

	typedef enum logic {
		REG_FILTER_BITS = 1'b0,
		REG_PROBE_COUNT = 1'b1
	} reg_idx_t;

	function automatic logic [31:0] rotr_step(input logic [31:0] h);
		return {h[STEP_ROT-1:0], h[31:STEP_ROT]};
	endfunction

	function automatic logic [4:0] clamp_probes(input logic [4:0] k);
		logic [4:0] r;
		r = k;
		if (k < MIN_PROBES) begin
			r = MIN_PROBES;
		end else if (k > MAX_PROBES) begin
			r = MAX_PROBES;
		end
		return r;
	endfunction

endpackage

@@ rtl/bfdh_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfdh_req_if
// Request channel: add or query of one key hash.
// ----------------------------------------------------------------------------
interface bfdh_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [31:0] key_hash;

	modport source (output valid, output req_type, output key_hash, input ready);
	modport sink   (input valid, input req_type, input key_hash, output ready);
endinterface

@@ rtl/bfdh_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfdh_rsp_if
// Response channel: membership answer of one query.
// ----------------------------------------------------------------------------
interface bfdh_rsp_if;
	logic valid;
	logic ready;
	logic maybe_present;

	modport source (output valid, output maybe_present, input ready);
	modport sink   (input valid, input maybe_present, output ready);
endinterface

@@ rtl/bfdh_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfdh_fifo
// Small register queue between the front and the probe engine.
// ----------------------------------------------------------------------------
module bfdh_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = bfdh_pkg::QUEUE_DEPTH,
	localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW   = $clog2(DEPTH + 1)
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);

	logic [W-1:0]  slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

@@ rtl/bfdh_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfdh_front
// Takes requests and reduces hash, step and 2^32 modulo the bit count.
// ----------------------------------------------------------------------------
module bfdh_front #(
	parameter int MAX_BITS = bfdh_pkg::MAX_BITS_DEFAULT,
	localparam int NW      = $clog2(MAX_BITS + 1),
	localparam int EW      = 1 + 32 + 3 * NW
) (
	input  logic          clk,
	input  logic          arst_n,
	bfdh_req_if.sink      req,
	input  logic [NW-1:0] nbits,
	input  logic          clearing,
	output logic          push,
	output logic [EW-1:0] entry,
	input  logic          full
);

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_DIV  = 3'b010,
		F_PUSH = 3'b100
	} fstate_t;

	typedef struct packed {
		logic          query;
		logic [31:0]   hash;
		logic [NW-1:0] r;
		logic [NW-1:0] s;
		logic [NW-1:0] c;
	} ent_t;

	fstate_t                      state_q;
	logic [bfdh_pkg::DIV_CW-1:0]  cnt_q;
	logic                         query_q;
	logic [31:0]                  hash_q;
	logic [31:0]                  dvd_q [bfdh_pkg::LANES];
	logic [NW-1:0]                rem_q [bfdh_pkg::LANES];
	logic [NW-1:0]                rem_d [bfdh_pkg::LANES];
	logic [NW:0]                  wrap_p1;
	ent_t                         ent;

	assign req.ready = (state_q == F_IDLE) && !clearing;

	// restoring remainder, DIV_BITS dividend bits per lane and cycle
	always_comb begin
		logic [NW:0]   w;
		logic [NW-1:0] t;
		for (int l = 0; l < bfdh_pkg::LANES; l++) begin
			t = rem_q[l];
			for (int b = 0; b < bfdh_pkg::DIV_BITS; b++) begin
				w = {t, dvd_q[l][31 - b]};
				if (w >= {1'b0, nbits}) begin
					w = w - {1'b0, nbits};
				end
				t = w[NW-1:0];
			end
			rem_d[l] = t;
		end
	end

	// 2^32 mod n = ((2^32 - 1) mod n) + 1, folded once more
	assign wrap_p1 = {1'b0, rem_q[bfdh_pkg::LANE_WRAP]} + 1'b1;

	always_comb begin
		ent.query = query_q;
		ent.hash  = hash_q;
		ent.r     = rem_q[bfdh_pkg::LANE_HASH];
		ent.s     = rem_q[bfdh_pkg::LANE_STEP];
		ent.c     = (wrap_p1 == {1'b0, nbits}) ? '0 : wrap_p1[NW-1:0];
	end

	assign entry = ent;
	assign push  = (state_q == F_PUSH) && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (req.valid && req.ready) begin
						cnt_q   <= '0;
						state_q <= F_DIV;
					end
				end
				F_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == bfdh_pkg::DIV_CW'(bfdh_pkg::DIV_STEPS - 1)) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (!full) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && req.valid && req.ready) begin
			query_q                       <= req.req_type;
			hash_q                        <= req.key_hash;
			dvd_q[bfdh_pkg::LANE_HASH]    <= req.key_hash;
			dvd_q[bfdh_pkg::LANE_STEP]    <= bfdh_pkg::rotr_step(req.key_hash);
			dvd_q[bfdh_pkg::LANE_WRAP]    <= '1;
			for (int l = 0; l < bfdh_pkg::LANES; l++) begin
				rem_q[l] <= '0;
			end
		end else if (state_q == F_DIV) begin
			for (int l = 0; l < bfdh_pkg::LANES; l++) begin
				rem_q[l] <= rem_d[l];
				dvd_q[l] <= dvd_q[l] << bfdh_pkg::DIV_BITS;
			end
		end
	end

endmodule

@@ rtl/bfdh_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfdh_back
// Probe engine: walks the probe positions over the bit store, one a cycle.
// ----------------------------------------------------------------------------
module bfdh_back #(
	parameter int MAX_BITS = bfdh_pkg::MAX_BITS_DEFAULT,
	localparam int NW      = $clog2(MAX_BITS + 1),
	localparam int AW      = $clog2(MAX_BITS),
	localparam int EW      = 1 + 32 + 3 * NW
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [NW-1:0] nbits,
	input  logic [4:0]    probes,
	input  logic          empty,
	input  logic [EW-1:0] entry,
	output logic          pop,
	output logic          clearing,
	bfdh_rsp_if.source    rsp
);

	typedef enum logic [4:0] {
		B_CLEAR = 5'b00001,
		B_IDLE  = 5'b00010,
		B_PROBE = 5'b00100,
		B_DRAIN = 5'b01000,
		B_DONE  = 5'b10000
	} bstate_t;

	typedef struct packed {
		logic          query;
		logic [31:0]   hash;
		logic [NW-1:0] r;
		logic [NW-1:0] s;
		logic [NW-1:0] c;
	} ent_t;

	ent_t          ent;
	bstate_t       state_q;
	logic [AW-1:0] clr_addr_q;
	logic          query_q;
	logic [31:0]   h_q;
	logic [31:0]   step_q;
	logic [NW-1:0] r_q;
	logic [NW-1:0] s_q;
	logic [NW-1:0] c_q;
	logic [4:0]    cnt_q;
	logic          all_q;
	logic          rd_pend_q;
	logic          out_valid_q;
	logic          out_bit_q;
	logic [NW-1:0] r_next;
	logic [31:0]   h_next;
	logic [AW-1:0] pos;
	logic          last;
	logic          emit;

	logic          mem [MAX_BITS];
	logic          mem_rd_q;
	logic          we;
	logic [AW-1:0] waddr;

	assign ent      = ent_t'(entry);
	assign clearing = (state_q == B_CLEAR);
	assign pop      = (state_q == B_IDLE) && !empty;
	assign pos      = r_q[AW-1:0];
	assign last     = (cnt_q == 5'(probes - 5'd1));
	assign emit     = (state_q == B_DONE) && (!out_valid_q || rsp.ready);

	// next position modulo n, correcting when the hash wraps 2^32
	always_comb begin
		logic [NW:0] t1;
		logic [NW:0] t2;
		logic        carry;
		t1 = {1'b0, r_q} + {1'b0, s_q};
		if (t1 >= {1'b0, nbits}) begin
			t1 = t1 - {1'b0, nbits};
		end
		{carry, h_next} = {1'b0, h_q} + {1'b0, step_q};
		t2 = t1;
		if (carry) begin
			if (t1 >= {1'b0, c_q}) begin
				t2 = t1 - {1'b0, c_q};
			end else begin
				t2 = t1 + {1'b0, nbits} - {1'b0, c_q};
			end
		end
		r_next = t2[NW-1:0];
	end

	assign we    = clearing || ((state_q == B_PROBE) && !query_q);
	assign waddr = clearing ? clr_addr_q : pos;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= !clearing;
		end
		mem_rd_q <= mem[pos];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_CLEAR;
			clr_addr_q  <= '0;
			cnt_q       <= '0;
			all_q       <= 1'b1;
			rd_pend_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_pend_q <= (state_q == B_PROBE) && query_q;
			if (rd_pend_q) begin
				all_q <= all_q & mem_rd_q;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == AW'(MAX_BITS - 1)) begin
						state_q <= B_IDLE;
					end
				end
				B_IDLE: begin
					if (!empty) begin
						cnt_q   <= '0;
						all_q   <= 1'b1;
						state_q <= B_PROBE;
					end
				end
				B_PROBE: begin
					cnt_q <= cnt_q + 1'b1;
					if (last) begin
						state_q <= query_q ? B_DRAIN : B_IDLE;
					end
				end
				B_DRAIN: begin
					state_q <= B_DONE;
				end
				B_DONE: begin
					if (emit) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			query_q <= ent.query;
			h_q     <= ent.hash;
			step_q  <= bfdh_pkg::rotr_step(ent.hash);
			r_q     <= ent.r;
			s_q     <= ent.s;
			c_q     <= ent.c;
		end else if (state_q == B_PROBE) begin
			h_q <= h_next;
			r_q <= r_next;
		end
		if (emit) begin
			out_bit_q <= all_q;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.maybe_present = out_bit_q;

endmodule

@@ rtl/bloom_filter_double_hash_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bloom_filter_double_hash_top
// Bloom filter with double hashing over an on-chip bit store.
// ----------------------------------------------------------------------------
// req carries req_type (0 add, 1 query) and a 32-bit key_hash; rsp carries
// maybe_present, one per query and none per add. Both are valid/ready.
// The APB port holds filter_bits at 0x0 and probe_count at 0x4; write them
// only while no request is in flight.
// The front reduces hash, probe step and 2^32 modulo the bit count in a
// 4-bit-per-cycle remainder unit and takes a new request only once it has
// pushed the last one. A 2-entry queue feeds the probe engine, which visits
// the k = probe_count probe positions in turn; a query then waits in a
// drain state for its last store read before it answers.
// After reset the store is cleared one bit a cycle over all MAX_BITS bits
// (8192 by default) and req.ready stays low until that is done.
// A stalled response holds the engine only at the end of the next query;
// the front keeps taking requests until the queue is full.
// ----------------------------------------------------------------------------
module bloom_filter_double_hash_top #(
	parameter int MAX_BITS = bfdh_pkg::MAX_BITS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	bfdh_req_if.sink    req,
	bfdh_rsp_if.source  rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int NW = $clog2(MAX_BITS + 1);
	localparam int EW = 1 + 32 + 3 * NW;

	logic [13:0]        filter_bits_q;
	logic [4:0]         probe_count_q;
	bfdh_pkg::reg_idx_t reg_idx;
	logic               wr_en;
	logic [31:0]        fb_wide;
	logic [NW-1:0]      nbits;
	logic [4:0]         probes;
	logic               push;
	logic               pop;
	logic               full;
	logic               empty;
	logic               clearing;
	logic [EW-1:0]      push_entry;
	logic [EW-1:0]      pop_entry;

	assign pready  = 1'b1;
	assign reg_idx = bfdh_pkg::reg_idx_t'(paddr[2]);
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_bits_q <= bfdh_pkg::FILTER_BITS_RST;
			probe_count_q <= bfdh_pkg::PROBE_COUNT_RST;
		end else if (wr_en) begin
			case (reg_idx)
				bfdh_pkg::REG_FILTER_BITS: filter_bits_q <= pwdata[13:0];
				bfdh_pkg::REG_PROBE_COUNT: probe_count_q <= pwdata[4:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			bfdh_pkg::REG_FILTER_BITS: prdata = {18'd0, filter_bits_q};
			bfdh_pkg::REG_PROBE_COUNT: prdata = {27'd0, probe_count_q};
			default:                   prdata = '0;
		endcase
	end

	assign fb_wide = 32'(filter_bits_q);
	assign nbits   = (fb_wide < 32'(bfdh_pkg::MIN_FILTER_BITS)) ?
	                 NW'(bfdh_pkg::MIN_FILTER_BITS) :
	                 (fb_wide > 32'(MAX_BITS)) ? NW'(MAX_BITS) : NW'(fb_wide);
	assign probes  = bfdh_pkg::clamp_probes(probe_count_q);

	bfdh_front #(
		.MAX_BITS (MAX_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.nbits    (nbits),
		.clearing (clearing),
		.push     (push),
		.entry    (push_entry),
		.full     (full)
	);

	bfdh_fifo #(
		.W     (EW),
		.DEPTH (bfdh_pkg::QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_entry),
		.full   (full),
		.pop    (pop),
		.rdata  (pop_entry),
		.empty  (empty)
	);

	bfdh_back #(
		.MAX_BITS (MAX_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.nbits    (nbits),
		.probes   (probes),
		.empty    (empty),
		.entry    (pop_entry),
		.pop      (pop),
		.clearing (clearing),
		.rsp      (rsp)
	);

	a_no_req_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !req.ready)
		else $error("request taken during store clear");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue overflow");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue underflow");

	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> !empty)
		else $error("pushed entry lost");

endmodule
